// ----- hw/rtl/modexp_pkg.sv -----
package modexp_pkg;

   // Width of the register index on the write port
   localparam int CSR_INDEX_WIDTH = 1;

   // Register map of the write port
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_EXPONENT = 1'b0,
      REG_MODULUS  = 1'b1
   } csr_reg_type;

   // Commands from the controller to the datapath
   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_LOAD      = 3'd1,
      CMD_START_RED = 3'd2,
      CMD_START_ACC = 3'd3,
      CMD_START_SQ  = 3'd4,
      CMD_STEP      = 3'd5
   } dp_cmd_type;

   // Destination of a finished modular product
   typedef enum logic [1:0] {
      DST_RED = 2'd0,
      DST_ACC = 2'd1,
      DST_SQ  = 2'd2
   } dst_type;

   // Status from the datapath to the controller
   typedef struct packed {
      logic e_zero;
      logic e_lsb;
      logic mul_last;
   } dp_status_type;

endpackage

// ----- hw/rtl/modular_exponentiation_top.sv -----
// Modular exponentiation: each item on the req_ channel carries one base; the rsp_
// channel returns base to the configured exponent modulo the configured modulus.
// An exponent of zero returns 1. A modulus of zero acts as 2^WIDTH.
// Load the exponent (index 0) and modulus (index 1) on the csr_ port while idle.
// One item is in work at a time; a shared shift-and-add modular multiplier does
// one multiplier bit per cycle.
// The finished result sits in an output register, so the next item is accepted
// while it waits; req_stall rises from acceptance until the work is done and,
// should the previous result still wait, until that one is taken.
// Holding rsp_stall high holds rsp_valid and rsp_power_result steady.
// Synchronous reset drops any item in work, empties the output register and sets
// the exponent to 0 and the modulus to 1.
module modular_exponentiation_top
   import modexp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]           csr_write_data,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [WIDTH-1:0]           req_base,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [WIDTH-1:0]           rsp_power_result
);

   dp_cmd_type       cmd;
   dp_status_type    status;
   logic             load_rsp;
   logic             rsp_free;
   logic [WIDTH-1:0] result;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [WIDTH-1:0] rsp_data_ff, rsp_data_in;

   modexp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_free  (rsp_free),
      .status    (status),
      .cmd       (cmd),
      .load_rsp  (load_rsp)
   );

   modexp_dp #(
      .WIDTH (WIDTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .req_base       (req_base),
      .cmd            (cmd),
      .status         (status),
      .result         (result)
   );

   // Output register: free when empty or being taken this cycle
   assign rsp_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = load_rsp ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_data_ff;

   // Never overwrite a result that is still waiting
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |-> (!rsp_valid_ff || !rsp_stall))
      else $error("output register overwritten while stalled");

   // An accepted item starts a load of the datapath
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> (cmd == CMD_LOAD))
      else $error("item accepted without datapath load");

   // Busy after acceptance
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("second item accepted while busy");

   // A loaded result is shown next cycle
   assert property (@(posedge clock) disable iff (reset)
      load_rsp |=> rsp_valid)
      else $error("loaded result not presented");

endmodule

// ----- hw/rtl/modexp_dp.sv -----
module modexp_dp
   import modexp_pkg::*;
#(
   parameter int WIDTH = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [WIDTH-1:0]           csr_write_data,
   input  logic [WIDTH-1:0]           req_base,
   input  dp_cmd_type                 cmd,
   output dp_status_type              status,
   output logic [WIDTH-1:0]           result
);

   localparam int CNT_W = $clog2(WIDTH);

   // (x + y) mod n for x, y below n; a zero modulus means plain wrap
   function automatic logic [WIDTH-1:0] add_mod(
      input logic [WIDTH-1:0] x,
      input logic [WIDTH-1:0] y,
      input logic [WIDTH-1:0] n,
      input logic             n_zero
   );
      logic [WIDTH:0] sum;
      logic [WIDTH:0] diff;
      sum  = {1'b0, x} + {1'b0, y};
      diff = sum - {1'b0, n};
      if (n_zero) begin
         add_mod = sum[WIDTH-1:0];
      end else if (diff[WIDTH]) begin
         add_mod = sum[WIDTH-1:0];
      end else begin
         add_mod = diff[WIDTH-1:0];
      end
   endfunction

   logic [WIDTH-1:0] exp_cfg_ff, exp_cfg_in;
   logic [WIDTH-1:0] mod_cfg_ff, mod_cfg_in;
   logic [WIDTH-1:0] n_ff, n_in;
   logic [WIDTH-1:0] e_ff, e_in;
   logic [WIDTH-1:0] sq_ff, sq_in;
   logic [WIDTH-1:0] acc_ff, acc_in;
   logic [WIDTH-1:0] a_ff, a_in;
   logic [WIDTH-1:0] b_ff, b_in;
   logic [WIDTH-1:0] r_ff, r_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   dst_type          dst_ff, dst_in;

   logic             n_zero;
   logic [WIDTH-1:0] r_dbl;
   logic [WIDTH-1:0] r_add;
   logic [WIDTH-1:0] r_step;

   // Capture register writes
   always_comb begin
      exp_cfg_in = exp_cfg_ff;
      mod_cfg_in = mod_cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            REG_EXPONENT: exp_cfg_in = csr_write_data;
            REG_MODULUS:  mod_cfg_in = csr_write_data;
            default: ;
         endcase
      end
   end

   // One bit of the shift-and-add modular product: double, then add when the top bit of b is set
   assign n_zero = (n_ff == '0);
   assign r_dbl  = add_mod(r_ff, r_ff, n_ff, n_zero);
   assign r_add  = add_mod(r_dbl, a_ff, n_ff, n_zero);
   assign r_step = b_ff[WIDTH-1] ? r_add : r_dbl;

   // Operand and result registers
   always_comb begin
      n_in   = n_ff;
      e_in   = e_ff;
      sq_in  = sq_ff;
      acc_in = acc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      r_in   = r_ff;
      cnt_in = cnt_ff;
      dst_in = dst_ff;
      unique case (cmd)
         CMD_NONE: ;
         CMD_LOAD: begin
            n_in  = mod_cfg_ff;
            e_in  = exp_cfg_ff;
            sq_in = req_base;
            if (exp_cfg_ff != '0 && mod_cfg_ff == WIDTH'(1)) begin
               acc_in = '0;
            end else begin
               acc_in = WIDTH'(1);
            end
         end
         CMD_START_RED: begin
            // base times (1 mod n) reduces the base
            a_in   = (n_ff == WIDTH'(1)) ? '0 : WIDTH'(1);
            b_in   = sq_ff;
            r_in   = '0;
            cnt_in = CNT_W'(WIDTH - 1);
            dst_in = DST_RED;
         end
         CMD_START_ACC: begin
            a_in   = acc_ff;
            b_in   = sq_ff;
            r_in   = '0;
            cnt_in = CNT_W'(WIDTH - 1);
            dst_in = DST_ACC;
         end
         CMD_START_SQ: begin
            a_in   = sq_ff;
            b_in   = sq_ff;
            r_in   = '0;
            cnt_in = CNT_W'(WIDTH - 1);
            dst_in = DST_SQ;
         end
         CMD_STEP: begin
            r_in   = r_step;
            b_in   = {b_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff - CNT_W'(1);
            if (cnt_ff == '0) begin
               unique case (dst_ff)
                  DST_RED: sq_in = r_step;
                  DST_ACC: acc_in = r_step;
                  DST_SQ: begin
                     sq_in = r_step;
                     e_in  = {1'b0, e_ff[WIDTH-1:1]};
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cfg_ff <= '0;
         mod_cfg_ff <= WIDTH'(1);
      end else begin
         exp_cfg_ff <= exp_cfg_in;
         mod_cfg_ff <= mod_cfg_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      e_ff   <= e_in;
      sq_ff  <= sq_in;
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      r_ff   <= r_in;
      cnt_ff <= cnt_in;
      dst_ff <= dst_in;
   end

   assign status.e_zero   = (e_ff == '0);
   assign status.e_lsb    = e_ff[0];
   assign status.mul_last = (cnt_ff == '0);
   assign result          = acc_ff;

endmodule

// ----- hw/rtl/modexp_ctrl.sv -----
module modexp_ctrl
   import modexp_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  logic          rsp_free,
   input  dp_status_type status,
   output dp_cmd_type    cmd,
   output logic          load_rsp
);

   typedef enum logic [7:0] {
      ST_IDLE     = 8'b0000_0001,
      ST_CHECK    = 8'b0000_0010,
      ST_REDUCE   = 8'b0000_0100,
      ST_PICK     = 8'b0000_1000,
      ST_MUL_ACC  = 8'b0001_0000,
      ST_START_SQ = 8'b0010_0000,
      ST_MUL_SQ   = 8'b0100_0000,
      ST_DONE     = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // Take a new item only when idle and out of reset
   assign req_stall = reset || (state_ff != ST_IDLE);

   // Sequence the reduction and the square-and-multiply passes
   always_comb begin
      state_in = state_ff;
      cmd      = CMD_NONE;
      load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid && !reset) begin
               cmd      = CMD_LOAD;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.e_zero) begin
               state_in = ST_DONE;
            end else begin
               cmd      = CMD_START_RED;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            cmd = CMD_STEP;
            if (status.mul_last) begin
               state_in = ST_PICK;
            end
         end
         ST_PICK: begin
            priority if (status.e_zero) begin
               state_in = ST_DONE;
            end else if (status.e_lsb) begin
               cmd      = CMD_START_ACC;
               state_in = ST_MUL_ACC;
            end else begin
               cmd      = CMD_START_SQ;
               state_in = ST_MUL_SQ;
            end
         end
         ST_MUL_ACC: begin
            cmd = CMD_STEP;
            if (status.mul_last) begin
               state_in = ST_START_SQ;
            end
         end
         ST_START_SQ: begin
            cmd      = CMD_START_SQ;
            state_in = ST_MUL_SQ;
         end
         ST_MUL_SQ: begin
            cmd = CMD_STEP;
            if (status.mul_last) begin
               state_in = ST_PICK;
            end
         end
         ST_DONE: begin
            // Hold until the output register can take the item
            if (rsp_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
